[hw/rtl/lcs_pkg.sv]
// Shared types and constants for the LED driver configuration sequencer.
// Holds the microcode word layout, sequencer opcodes and phase codes.
// No dependencies.
package lcs_pkg;

    localparam int MAX_CHAIN_DEF = 6;
    localparam int CHAIN_W = 3;
    localparam int GAIN_W = 7;
    localparam int BYTE_W = 8;
    localparam int BIT_CNT_W = $clog2(BYTE_W);
    localparam int STEP_W = 4;

    localparam logic [1:0] PH_ENTER = 2'd0;
    localparam logic [1:0] PH_SHIFT = 2'd1;
    localparam logic [1:0] PH_EXIT = 2'd2;

    typedef enum logic [1:0] {
        OP_NEXT,
        OP_SKIP_EMPTY,
        OP_DATA_LOOP,
        OP_END
    } op_t;

    typedef struct packed {
        logic [1:0]        phase;
        logic              oe;
        logic              le;
        logic              data_en;
        op_t               op;
        logic [STEP_W-1:0] target;
    } ucode_t;

endpackage

[hw/rtl/lcs_ucode_rom.sv]
// Microcode program of the configuration-write sequence, one word per step.
// Depends on lcs_pkg for the control word layout and opcodes.
module lcs_ucode_rom
    import lcs_pkg::*;
(
    input  logic [STEP_W-1:0] step,
    output ucode_t            word
);

    localparam logic [STEP_W-1:0] STEP_EXIT = STEP_W'(6);

    always_comb
    begin
        word = '{phase: PH_EXIT, oe: 1'b1, le: 1'b0, data_en: 1'b0,
                 op: OP_END, target: '0};
        case (step)
            STEP_W'(0):  word = '{PH_ENTER, 1'b1, 1'b0, 1'b0, OP_NEXT, '0};
            STEP_W'(1):  word = '{PH_ENTER, 1'b0, 1'b0, 1'b0, OP_NEXT, '0};
            STEP_W'(2):  word = '{PH_ENTER, 1'b1, 1'b0, 1'b0, OP_NEXT, '0};
            STEP_W'(3):  word = '{PH_ENTER, 1'b1, 1'b1, 1'b0, OP_NEXT, '0};
            STEP_W'(4):  word = '{PH_ENTER, 1'b1, 1'b0, 1'b0, OP_SKIP_EMPTY, STEP_EXIT};
            STEP_W'(5):  word = '{PH_SHIFT, 1'b1, 1'b0, 1'b1, OP_DATA_LOOP, '0};
            STEP_W'(6):  word = '{PH_EXIT, 1'b1, 1'b0, 1'b0, OP_NEXT, '0};
            STEP_W'(7):  word = '{PH_EXIT, 1'b0, 1'b0, 1'b0, OP_NEXT, '0};
            STEP_W'(8):  word = '{PH_EXIT, 1'b1, 1'b0, 1'b0, OP_NEXT, '0};
            STEP_W'(9):  word = '{PH_EXIT, 1'b1, 1'b0, 1'b0, OP_NEXT, '0};
            STEP_W'(10): word = '{PH_EXIT, 1'b1, 1'b0, 1'b0, OP_END, '0};
            default:     word = '{PH_EXIT, 1'b1, 1'b0, 1'b0, OP_END, '0};
        endcase
    end

endmodule

[hw/rtl/led_driver_config_sequencer.sv]
// Top level of the LED driver configuration-write sequencer.
// Depends on lcs_pkg and lcs_ucode_rom.
//
//   channel | signals                              | direction
//   in      | in_valid, in_stall, gain, flag       | request item in
//   out     | out_valid, out_stall, pin levels     | one item per pulse out
//   cfg     | cfg_write_en, cfg_write_data         | chain length write
//
// A request produces 10 + 8 * chips items, one per cycle while out_stall is low,
// so up to 58 items; the microcode step counter issues one control word a cycle
// unless a stall holds it.
// A new request is taken once the final item is in the output register.
// Reset sets the chain length to one and empties the sequencer.
// A stall holds the output register and freezes the step counter.
module led_driver_config_sequencer
    import lcs_pkg::*;
#(
    parameter int MAX_CHAIN = MAX_CHAIN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [GAIN_W-1:0]  current_gain,
    input  logic               high_current,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         phase,
    output logic               data_bit,
    output logic               latch_enable,
    output logic               output_enable,
    output logic               last_pulse,
    input  logic               cfg_write_en,
    input  logic [CHAIN_W-1:0] cfg_write_data
);

    logic [CHAIN_W-1:0]   chain_length_reg;
    logic                 busy_reg;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [BYTE_W-1:0]    cfg_byte_reg;
    logic [BYTE_W-1:0]    shift_reg;
    logic [BIT_CNT_W-1:0] bit_reg;
    logic [CHAIN_W-1:0]   chips_reg;
    logic [CHAIN_W-1:0]   chip_left_reg;
    logic                 out_valid_reg;
    logic [1:0]           phase_reg;
    logic                 data_bit_reg;
    logic                 le_reg;
    logic                 oe_reg;
    logic                 last_reg;

    ucode_t               word;
    logic                 accept;
    logic                 advance;
    logic                 byte_done;
    logic                 data_done;
    logic [CHAIN_W-1:0]   chips_sat;
    logic [BYTE_W-1:0]    new_byte;

    lcs_ucode_rom u_rom
    (
        .step (step_reg),
        .word (word)
    );

    assign in_stall  = busy_reg;
    assign accept    = in_valid && !busy_reg;
    assign advance   = busy_reg && (!out_valid_reg || !out_stall);
    assign byte_done = (bit_reg == BIT_CNT_W'(BYTE_W - 1));
    assign data_done = byte_done && (chip_left_reg == '0);
    assign chips_sat = (chain_length_reg > CHAIN_W'(MAX_CHAIN)) ?
                       CHAIN_W'(MAX_CHAIN) : chain_length_reg;
    assign new_byte  = {current_gain[GAIN_W-2:0], current_gain[GAIN_W-1], high_current};

    always_comb
    begin
        step_next = step_reg + STEP_W'(1);
        case (word.op)
            OP_NEXT:       step_next = step_reg + STEP_W'(1);
            OP_SKIP_EMPTY: step_next = (chips_reg == '0) ? word.target :
                                       step_reg + STEP_W'(1);
            OP_DATA_LOOP:  step_next = data_done ? step_reg + STEP_W'(1) : step_reg;
            OP_END:        step_next = '0;
            default:       step_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_length_reg <= CHAIN_W'(1);
            busy_reg         <= 1'b0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                chain_length_reg <= cfg_write_data;
            end
            if (accept)
            begin
                busy_reg      <= 1'b1;
                step_reg      <= '0;
                cfg_byte_reg  <= new_byte;
                shift_reg     <= new_byte;
                bit_reg       <= '0;
                chips_reg     <= chips_sat;
                chip_left_reg <= chips_sat - CHAIN_W'(1);
            end
            else if (advance)
            begin
                step_reg <= step_next;
                if (word.op == OP_END)
                begin
                    busy_reg <= 1'b0;
                end
                if (word.data_en)
                begin
                    bit_reg <= bit_reg + BIT_CNT_W'(1);
                    if (byte_done)
                    begin
                        shift_reg     <= cfg_byte_reg;
                        chip_left_reg <= chip_left_reg - CHAIN_W'(1);
                    end
                    else
                    begin
                        shift_reg <= {shift_reg[BYTE_W-2:0], 1'b0};
                    end
                end
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= word.phase;
                data_bit_reg  <= word.data_en && shift_reg[BYTE_W-1];
                le_reg        <= word.data_en ? data_done : word.le;
                oe_reg        <= word.oe;
                last_reg      <= (word.op == OP_END);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase         = phase_reg;
    assign data_bit      = data_bit_reg;
    assign latch_enable  = le_reg;
    assign output_enable = oe_reg;
    assign last_pulse    = last_reg;

endmodule

[hw/rtl/lcs_checker.sv]
// Port-level checks for the LED driver configuration sequencer.
// Depends on lcs_pkg; bound to led_driver_config_sequencer below.
module lcs_checker
    import lcs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         phase,
    input logic               data_bit,
    input logic               latch_enable,
    input logic               output_enable,
    input logic               last_pulse
);

    // A stalled item stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(phase) && $stable(data_bit)
        && $stable(latch_enable) && $stable(output_enable) && $stable(last_pulse))
        else $error("output item changed while stalled");

    // An accepted request blocks further requests until its sequence is issued.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while a sequence is running");

    // The final pulse belongs to the return-to-normal part with output enabled.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pulse |-> phase == PH_EXIT && output_enable && !latch_enable)
        else $error("last pulse outside the exit part");

    // Data is only driven while shifting, and output stays enabled there.
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (data_bit || phase == PH_SHIFT) |-> phase == PH_SHIFT && output_enable)
        else $error("data pin active outside the shift part");

endmodule

bind led_driver_config_sequencer lcs_checker u_lcs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .phase         (phase),
    .data_bit      (data_bit),
    .latch_enable  (latch_enable),
    .output_enable (output_enable),
    .last_pulse    (last_pulse)
);
